FILE: rtl/core/clo_pkg.sv
// Shared types, widths and codes for the combinadic ladder operator.
// No dependencies; imported by clo_binom_mem and the top level.
package clo_pkg;

  localparam int MAX_STATES_DEF = 32;
  localparam int ORB_W          = 6;            // orbital labels and particle counts
  localparam int RANK_W         = 30;           // ranks and binomial values
  localparam int IDX_W          = 8;            // signed row/column index into the table
  localparam int PF_W           = RANK_W + 6;   // signed accumulator for the result rank

  localparam logic [ORB_W-1:0]        NUM_STATES_RST = 6'd32;
  localparam logic signed [IDX_W-1:0] IDX_ONE        = 8'sd1;
  localparam logic signed [IDX_W-1:0] IDX_NEG_ONE    = -8'sd1;

  localparam logic OP_ANNIHILATE = 1'b0;
  localparam logic OP_CREATE     = 1'b1;

  // One read of C(row, col); reads outside the triangle return zero.
  typedef struct packed {
    logic signed [IDX_W-1:0] row;
    logic signed [IDX_W-1:0] col;
  } clo_rd_req_t;

  function automatic logic signed [IDX_W-1:0] to_idx(input logic [ORB_W-1:0] v);
    return signed'({{(IDX_W-ORB_W){1'b0}}, v});
  endfunction

endpackage

FILE: rtl/core/clo_binom_mem.sv
// Binomial coefficient memory: two registered read ports, Pascal fill sweep after reset.
// Depends on clo_pkg.
module clo_binom_mem
  import clo_pkg::*;
#(
  parameter int MAX_STATES = MAX_STATES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  clo_rd_req_t       rd0_req,
  input  clo_rd_req_t       rd1_req,
  output logic [RANK_W-1:0] rd0_data,
  output logic [RANK_W-1:0] rd1_data,
  output logic              fill_busy
);

  localparam int TBL_DIM = MAX_STATES + 1;
  localparam int DEPTH   = TBL_DIM * TBL_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int RC_W    = $clog2(TBL_DIM);

  localparam logic signed [IDX_W-1:0] IDX_LIM    = IDX_W'(MAX_STATES);
  localparam logic [AW-1:0]           ROW_STRIDE = AW'(TBL_DIM);
  localparam logic [AW-1:0]           LAST_IDX   = AW'(DEPTH - 1);
  localparam logic [RC_W-1:0]         LAST_RC    = RC_W'(MAX_STATES);

  logic [RANK_W-1:0] mem [DEPTH];

  logic              fill_act_r;
  logic [AW-1:0]     fill_idx_r;
  logic [RC_W-1:0]   fill_row_r;
  logic [RC_W-1:0]   fill_col_r;
  logic              wr_act_r;
  logic [AW-1:0]     wr_idx_r;
  logic              wr_row_zero_r;
  logic              wr_col_zero_r;
  logic [RANK_W-1:0] prev_r;
  logic [RANK_W-1:0] wr_data;
  logic [AW-1:0]     fill_raddr;

  logic              in0, in1;
  logic [AW-1:0]     addr0, addr1, raddr0;
  logic [RANK_W-1:0] q0_r, q1_r;
  logic              zero0_r, zero1_r;

  // Decode requests; anything outside the table reads as zero.
  always_comb begin
    in0 = !rd0_req.row[IDX_W-1] && !rd0_req.col[IDX_W-1] &&
          (rd0_req.row <= IDX_LIM) && (rd0_req.col <= IDX_LIM);
    in1 = !rd1_req.row[IDX_W-1] && !rd1_req.col[IDX_W-1] &&
          (rd1_req.row <= IDX_LIM) && (rd1_req.col <= IDX_LIM);
    addr0 = in0 ? AW'(rd0_req.row[RC_W-1:0]) * ROW_STRIDE + AW'(rd0_req.col[RC_W-1:0]) : '0;
    addr1 = in1 ? AW'(rd1_req.row[RC_W-1:0]) * ROW_STRIDE + AW'(rd1_req.col[RC_W-1:0]) : '0;
  end

  // Fill reads the entry one row up; C(n,k) = C(n-1,k-1) + C(n-1,k).
  assign fill_raddr = (fill_row_r == '0) ? '0 : fill_idx_r - ROW_STRIDE;
  assign raddr0     = fill_act_r ? fill_raddr : addr0;
  assign wr_data    = wr_col_zero_r ? RANK_W'(1) :
                      wr_row_zero_r ? '0 : prev_r + q0_r;

  always_ff @(posedge clk) begin
    if (wr_act_r) begin
      mem[wr_idx_r] <= wr_data;
    end
    q0_r          <= mem[raddr0];
    q1_r          <= mem[addr1];
    zero0_r       <= !in0;
    zero1_r       <= !in1;
    wr_idx_r      <= fill_idx_r;
    wr_row_zero_r <= (fill_row_r == '0);
    wr_col_zero_r <= (fill_col_r == '0);
    if (wr_act_r) begin
      prev_r <= q0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_act_r <= 1'b1;
      fill_idx_r <= '0;
      fill_row_r <= '0;
      fill_col_r <= '0;
      wr_act_r   <= 1'b0;
    end else begin
      wr_act_r <= fill_act_r;
      if (fill_act_r) begin
        fill_idx_r <= fill_idx_r + AW'(1);
        if (fill_col_r == LAST_RC) begin
          fill_col_r <= '0;
          fill_row_r <= fill_row_r + RC_W'(1);
        end else begin
          fill_col_r <= fill_col_r + RC_W'(1);
        end
        if (fill_idx_r == LAST_IDX) begin
          fill_act_r <= 1'b0;
        end
      end
    end
  end

  assign rd0_data  = zero0_r ? '0 : q0_r;
  assign rd1_data  = zero1_r ? '0 : q1_r;
  assign fill_busy = fill_act_r | wr_act_r;

endmodule

FILE: rtl/core/combinadic_ladder_operator_unit.sv
// Combinadic ladder operator, top level; depends on clo_pkg and clo_binom_mem.
// An item passes TOTAL, CHECK and BOUND, RUN for each orbital scanned (up to MAX_STATES),
// then FINISH and EMIT; items that vanish in the range checks skip RUN. One item at a time:
// the next item is taken once the result is registered and the unit is back in IDLE.
// Reset: the binomial memory is filled by a sweep over all (MAX_STATES+1)^2 entries, no item taken.
module combinadic_ladder_operator_unit
  import clo_pkg::*;
#(
  parameter int MAX_STATES = MAX_STATES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ORB_W-1:0]  cfg_num_states,
  // item in
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [ORB_W-1:0]  in_particle_count,
  input  logic [RANK_W-1:0] in_rank_in,
  input  logic [ORB_W-1:0]  in_target_orbital,
  input  logic [ORB_W-1:0]  in_scan_start,
  // result out
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RANK_W-1:0] out_rank_out,
  output logic              out_vanished,
  output logic              out_phase_negative
);

  // Sequencer states: FILL waits for the table sweep, TOTAL/CHECK/BOUND are setup reads,
  // RUN walks one orbital per cycle, FINISH applies the last pending subtract.
  typedef enum logic [7:0] {
    ST_FILL   = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_TOTAL  = 8'b0000_0100,
    ST_CHECK  = 8'b0000_1000,
    ST_BOUND  = 8'b0001_0000,
    ST_RUN    = 8'b0010_0000,
    ST_FINISH = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [ORB_W-1:0]         num_states_r, num_states_nxt;
  logic                     op_r, op_nxt;
  logic [ORB_W-1:0]         np_r, np_nxt;
  logic [RANK_W-1:0]        rank_r, rank_nxt;
  logic [ORB_W-1:0]         tgt_r, tgt_nxt;
  logic [ORB_W-1:0]         s0_r, s0_nxt;
  logic [RANK_W-1:0]        q_r, q_nxt;
  logic signed [PF_W-1:0]   pf_r, pf_nxt;
  logic [RANK_W-1:0]        b_r, b_nxt;
  logic [ORB_W-1:0]         k_r, k_nxt;
  logic [ORB_W-1:0]         j_r, j_nxt;
  logic                     occ_r, occ_nxt;
  logic                     first_r, first_nxt;
  logic                     sub_pend_r, sub_pend_nxt;
  logic                     neg_r, neg_nxt;
  logic                     kill_r, kill_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0]        out_rank_r, out_rank_nxt;
  logic                     out_van_r, out_van_nxt;
  logic                     out_phase_r, out_phase_nxt;

  clo_rd_req_t       rd0_req, rd1_req;
  logic [RANK_W-1:0] rd0_data, rd1_data;
  logic              fill_busy;

  logic [ORB_W-1:0]        ns;
  logic signed [IDX_W-1:0] ns_i, np_i, d_i, row_i;
  logic [ORB_W-1:0]        j0;
  logic [RANK_W-1:0]       a_val, b_val, q_sub;
  logic                    occ, after_tgt, at_tgt, below_tgt, last_orb;
  logic                    bad, pf_pos;

  clo_binom_mem #(
    .MAX_STATES (MAX_STATES)
  ) u_binom_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd0_req   (rd0_req),
    .rd1_req   (rd1_req),
    .rd0_data  (rd0_data),
    .rd1_data  (rd1_data),
    .fill_busy (fill_busy)
  );

  // Effective orbital count: values above the table size act as the table size.
  assign ns   = (num_states_r > ORB_W'(MAX_STATES)) ? ORB_W'(MAX_STATES) : num_states_r;
  assign ns_i = to_idx(ns);
  assign np_i = to_idx(np_r);
  // Column offset of the second coefficient before the target: +1 create, -1 annihilate.
  assign d_i  = (op_r == OP_CREATE) ? IDX_ONE : IDX_NEG_ONE;
  assign j0   = (op_r == OP_CREATE) ? ORB_W'(1) : s0_r;
  // Row below the current orbital, read ahead for the next orbital.
  assign row_i = ns_i - to_idx(j_r) - IDX_ONE;

  // Per-orbital datapath. The read ports hold C(n, k_prev) and C(n, k_prev-1) for the
  // current row n = ns - j; pick the one that matches the last occupancy decision.
  // The second coefficient comes from Pascal's rule when it was not read directly.
  always_comb begin
    a_val = (!first_r && occ_r) ? rd1_data : rd0_data;
    after_tgt = (j_r > tgt_r);
    if (after_tgt) begin
      b_val = a_val;
    end else if (first_r) begin
      b_val = rd1_data;
    end else if (op_r == OP_CREATE) begin
      b_val = occ_r ? rd0_data : b_r - rd0_data;
    end else begin
      b_val = occ_r ? b_r - rd1_data : rd1_data;
    end
    occ       = (q_r >= a_val);
    q_sub     = q_r - a_val;
    at_tgt    = (j_r == tgt_r);
    below_tgt = (j_r < tgt_r);
    last_orb  = (j_r == ns);
  end

  assign bad = (rank_r == '0) || (rank_r > rd0_data) || (tgt_r == '0) || (tgt_r > ns) ||
               ((op_r == OP_ANNIHILATE) && ((np_r == '0) || (tgt_r < s0_r)));
  assign pf_pos = !pf_r[PF_W-1] && (pf_r != '0);

  always_comb begin
    state_nxt      = state_r;
    num_states_nxt = num_states_r;
    op_nxt         = op_r;
    np_nxt         = np_r;
    rank_nxt       = rank_r;
    tgt_nxt        = tgt_r;
    s0_nxt         = s0_r;
    q_nxt          = q_r;
    pf_nxt         = pf_r;
    b_nxt          = b_r;
    k_nxt          = k_r;
    j_nxt          = j_r;
    occ_nxt        = occ_r;
    first_nxt      = first_r;
    sub_pend_nxt   = sub_pend_r;
    neg_nxt        = neg_r;
    kill_nxt       = kill_r;
    out_valid_nxt  = out_valid_r;
    out_rank_nxt   = out_rank_r;
    out_van_nxt    = out_van_r;
    out_phase_nxt  = out_phase_r;
    rd0_req        = '0;
    rd1_req        = '0;

    if (cfg_valid) begin
      num_states_nxt = cfg_num_states;
    end

    // Drop the result once taken.
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // The subtract decided in the previous orbital is applied here, from the registered b_r.
    if (((state_r == ST_RUN) || (state_r == ST_FINISH)) && sub_pend_r) begin
      pf_nxt = pf_r - signed'({{(PF_W-RANK_W){1'b0}}, b_r});
    end

    case (state_r)
      ST_FILL: begin
        if (!fill_busy) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_opcode;
          np_nxt       = in_particle_count;
          rank_nxt     = in_rank_in;
          tgt_nxt      = in_target_orbital;
          s0_nxt       = (in_scan_start == '0) ? ORB_W'(1) : in_scan_start;
          kill_nxt     = 1'b0;
          neg_nxt      = 1'b0;
          sub_pend_nxt = 1'b0;
          state_nxt    = ST_TOTAL;
        end
      end

      ST_TOTAL: begin
        // Fetch the state count C(ns,np) and the starting rank C(ns,np+d).
        rd0_req   = '{row: ns_i, col: np_i};
        rd1_req   = '{row: ns_i, col: np_i + d_i};
        state_nxt = ST_CHECK;
      end

      ST_CHECK: begin
        q_nxt   = rd0_data - rank_r;
        pf_nxt  = signed'({{(PF_W-RANK_W){1'b0}}, rd1_data});
        // Upper bound for the scan start row, needed when annihilating.
        rd0_req = '{row: ns_i - to_idx(s0_r) + IDX_ONE, col: np_i};
        if (bad) begin
          kill_nxt  = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_BOUND;
        end
      end

      ST_BOUND: begin
        // If the remainder does not fit below the scan start nothing is ever found
        // occupied, so the annihilation target reads empty.
        if ((op_r == OP_ANNIHILATE) && !(q_r < rd0_data)) begin
          kill_nxt  = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          rd0_req      = '{row: ns_i - to_idx(j0), col: np_i};
          rd1_req      = '{row: ns_i - to_idx(j0), col: np_i + d_i};
          j_nxt        = j0;
          k_nxt        = np_r;
          first_nxt    = 1'b1;
          occ_nxt      = 1'b0;
          sub_pend_nxt = 1'b0;
          state_nxt    = ST_RUN;
        end
      end

      ST_RUN: begin
        // Prefetch both candidate columns of the next row.
        rd0_req   = '{row: row_i, col: to_idx(k_r)};
        rd1_req   = '{row: row_i, col: to_idx(k_r) - IDX_ONE};
        j_nxt     = j_r + ORB_W'(1);
        first_nxt = 1'b0;
        b_nxt     = b_val;
        occ_nxt   = occ;
        if (op_r == OP_CREATE) begin
          if (occ && at_tgt) begin
            // Target already occupied.
            kill_nxt     = 1'b1;
            sub_pend_nxt = 1'b0;
            state_nxt    = ST_FINISH;
          end else begin
            sub_pend_nxt = occ || at_tgt;
            neg_nxt      = neg_r ^ (occ && below_tgt);
            if (occ) begin
              q_nxt = q_sub;
              k_nxt = k_r - ORB_W'(1);
            end
            if (last_orb) begin
              state_nxt = ST_FINISH;
            end
          end
        end else begin
          if (k_r == '0) begin
            // All particles found: vanish if the target was not among them.
            kill_nxt     = (j_r <= tgt_r);
            sub_pend_nxt = 1'b0;
            state_nxt    = ST_FINISH;
          end else begin
            sub_pend_nxt = occ && !at_tgt;
            neg_nxt      = neg_r ^ (occ && below_tgt);
            if (occ) begin
              q_nxt = q_sub;
              k_nxt = k_r - ORB_W'(1);
            end
            if (!occ && at_tgt) begin
              // Target empty.
              kill_nxt  = 1'b1;
              state_nxt = ST_FINISH;
            end else if (last_orb) begin
              state_nxt = ST_FINISH;
            end
          end
        end
      end

      ST_FINISH: begin
        sub_pend_nxt = 1'b0;
        state_nxt    = ST_EMIT;
      end

      ST_EMIT: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (kill_r || !pf_pos) begin
            out_rank_nxt  = '0;
            out_van_nxt   = 1'b1;
            out_phase_nxt = 1'b0;
          end else begin
            out_rank_nxt  = pf_r[RANK_W-1:0];
            out_van_nxt   = 1'b0;
            out_phase_nxt = neg_r;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      num_states_r <= NUM_STATES_RST;
      out_valid_r  <= 1'b0;
      sub_pend_r   <= 1'b0;
      kill_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      num_states_r <= num_states_nxt;
      out_valid_r  <= out_valid_nxt;
      sub_pend_r   <= sub_pend_nxt;
      kill_r       <= kill_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    np_r        <= np_nxt;
    rank_r      <= rank_nxt;
    tgt_r       <= tgt_nxt;
    s0_r        <= s0_nxt;
    q_r         <= q_nxt;
    pf_r        <= pf_nxt;
    b_r         <= b_nxt;
    k_r         <= k_nxt;
    j_r         <= j_nxt;
    occ_r       <= occ_nxt;
    first_r     <= first_nxt;
    neg_r       <= neg_nxt;
    out_rank_r  <= out_rank_nxt;
    out_van_r   <= out_van_nxt;
    out_phase_r <= out_phase_nxt;
  end

  assign cfg_ready          = 1'b1;
  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_rank_out       = out_rank_r;
  assign out_vanished       = out_van_r;
  assign out_phase_negative = out_phase_r;

endmodule
